@@ rtl/dwvr_pkg.sv @@
// Shared types and codes for the double-ended queue with value removal.
// No dependencies; every other file of the block imports this package.
package dwvr_pkg;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 6;
   // Number of slots in the queue; the occupancy field is sized for it.
   localparam int DEPTH  = 32;

   // Request codes carried on the request tuser.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_EMIT_FIRST = 3'd6,
      OP_EMIT_LAST  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RM_RD,
      S_RM_CHK,
      S_EM_RD,
      S_EM_OUT,
      S_DONE
   } state_type;

   // One result item as handed from the sequencer to the output register.
   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic                     has_word;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
      logic                     last;
   } result_type;

endpackage

@@ rtl/deque_with_value_removal.sv @@
// Top level of the double-ended queue with value removal: request and
// result stream ports, output register. Uses dwvr_pkg, dwvr_seq, dwvr_ram.
//
// The block holds up to DEPTH signed 32-bit words as a ring in one
// single-port-write, single-port-read memory. A request arrives on the
// req_ channel: tuser carries the request code (push front/back, pop
// front/back, remove value, clear, emit first N, emit last N) and tdata the
// operand. Results leave on the rsp_ channel: one status item per request,
// or one item per entry for an emit, the final one marked with tlast.
// Requests are handled one at a time; req_tready is high only while the
// sequencer is idle. Pushes, pops and clear go from the idle state to the
// done state, which hands the status to the result register. Value removal
// walks the occupied slots with one shared ring address unit, a read and a
// check state per slot. An emit of N entries does one memory read per entry.
// When the receiver stalls, the output register holds its item and the
// sequencer waits; nothing is dropped. Reset empties the queue and sets
// the front position to zero; the slot memory itself is not cleared.
module deque_with_value_removal
   import dwvr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] word, [37:32] occupancy, [39:38] zero
   output logic [2:0]  rsp_tuser,   // [0] has_word, [2:1] status
   output logic        rsp_tlast
);

   localparam int AW = $clog2(DEPTH);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic       res_valid;
   result_type res_item;
   logic       res_take;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff, rsp_item_in;

   dwvr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (op_type'(req_tuser)),
      .req_operand (req_tdata),
      .res_valid   (res_valid),
      .res_item    (res_item),
      .res_take    (res_take),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   dwvr_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register takes a new item when it is empty or when its
   // current item leaves in the same cycle.
   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.occupancy, rsp_item_ff.word};
   assign rsp_tuser  = {rsp_item_ff.status, rsp_item_ff.has_word};
   assign rsp_tlast  = rsp_item_ff.last;

endmodule

@@ rtl/dwvr_ring.sv @@
// Shared ring address unit: (base + offset) modulo DEPTH by one add and
// one compare-subtract. Uses dwvr_pkg for the depth.
module dwvr_ring
   import dwvr_pkg::*;
(
   input  logic [$clog2(DEPTH)-1:0] base,
   input  logic [$clog2(DEPTH)-1:0] offset,
   output logic [$clog2(DEPTH)-1:0] pos
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

   logic [AW:0] sum;
   logic [AW:0] wrapped;

   // Both operands are below DEPTH, so one subtraction brings the sum back.
   assign sum     = {1'b0, base} + {1'b0, offset};
   assign wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
   assign pos     = wrapped[AW-1:0];

endmodule

@@ rtl/dwvr_ram.sv @@
// Slot store of the queue: one write port and one read port with
// registered read data. Uses dwvr_pkg for the word width and the depth.
module dwvr_ram
   import dwvr_pkg::*;
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/dwvr_seq.sv @@
// Request sequencer: queue pointers, request decode and the walks for
// value removal and emits. Uses dwvr_pkg and the dwvr_ring address unit.
module dwvr_seq
   import dwvr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  op_type                   req_op,
   input  logic [WORD_W-1:0]        req_operand,
   output logic                     res_valid,
   output result_type               res_item,
   input  logic                     res_take,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [WORD_W-1:0]        wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [WORD_W-1:0]        rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] BACK_OFF = AW'(DEPTH - 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     wr_ff, wr_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     left_ff, left_in;
   logic [WORD_W-1:0] value_ff, value_in;
   status_type        status_ff, status_in;

   logic [AW-1:0] ring_off;
   logic [AW-1:0] ring_pos;
   logic          is_full;
   logic          is_empty;
   logic [CW-1:0] emit_n;
   logic          rm_done;

   dwvr_ring u_ring (
      .base   (front_ff),
      .offset (ring_off),
      .pos    (ring_pos)
   );

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);
   assign rm_done  = (CW'(rd_ff) + CW'(1) == count_ff);
   assign req_ready = (state_ff == S_IDLE);

   // Emit count: negative means zero, and it is capped at the occupancy.
   always_comb begin
      if (req_operand[WORD_W-1]) begin
         emit_n = '0;
      end else if (req_operand[WORD_W-2:0] > (WORD_W-1)'(count_ff)) begin
         emit_n = count_ff;
      end else begin
         emit_n = req_operand[CW-1:0];
      end
   end

   // The single ring unit is steered to the offset the current step needs.
   always_comb begin
      ring_off = '0;
      case (state_ff)
         S_IDLE: begin
            case (req_op)
               OP_PUSH_FRONT: ring_off = BACK_OFF;
               OP_PUSH_BACK:  ring_off = count_ff[AW-1:0];
               OP_POP_FRONT:  ring_off = AW'(1);
               default:       ring_off = '0;
            endcase
         end
         S_RM_RD:  ring_off = rd_ff;
         S_RM_CHK: ring_off = wr_ff[AW-1:0];
         S_EM_RD:  ring_off = idx_ff;
         default:  ring_off = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_REMOVE:     state_in = is_empty ? S_DONE : S_RM_RD;
                  OP_EMIT_FIRST,
                  OP_EMIT_LAST:  state_in = (emit_n == '0) ? S_DONE : S_EM_RD;
                  default:       state_in = S_DONE;
               endcase
            end
         end
         S_RM_RD:  state_in = S_RM_CHK;
         S_RM_CHK: state_in = rm_done ? S_DONE : S_RM_RD;
         S_EM_RD:  state_in = S_EM_OUT;
         S_EM_OUT: begin
            if (res_take) begin
               state_in = (left_ff == CW'(1)) ? S_IDLE : S_EM_RD;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      value_in  = value_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = ring_pos;
      wr_data   = req_operand;
      rd_en     = 1'b0;
      rd_addr   = ring_pos;
      res_valid = 1'b0;
      res_item  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = ST_OK;
               unique case (req_op)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        front_in = ring_pos;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        front_in = ring_pos;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end
                     rd_in    = '0;
                     wr_in    = '0;
                     value_in = req_operand;
                  end
                  OP_CLEAR: begin
                     front_in = '0;
                     count_in = '0;
                  end
                  OP_EMIT_FIRST,
                  OP_EMIT_LAST: begin
                     left_in = emit_n;
                     if (req_op == OP_EMIT_LAST) begin
                        idx_in = AW'(count_ff - emit_n);
                     end else begin
                        idx_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RM_RD: begin
            rd_en = 1'b1;
         end
         S_RM_CHK: begin
            // Survivors are written back at the compacted position.
            if (rd_data != value_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               wr_in   = wr_ff + CW'(1);
            end
            rd_in = rd_ff + AW'(1);
            if (rm_done) begin
               count_in = wr_in;
            end
         end
         S_EM_RD: begin
            rd_en = 1'b1;
         end
         S_EM_OUT: begin
            res_valid          = 1'b1;
            res_item.word      = rd_data;
            res_item.has_word  = 1'b1;
            res_item.status    = ST_OK;
            res_item.occupancy = OCC_W'(count_ff);
            res_item.last      = (left_ff == CW'(1));
            if (res_take) begin
               left_in = left_ff - CW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end
         S_DONE: begin
            res_valid          = 1'b1;
            res_item.status    = status_ff;
            res_item.occupancy = OCC_W'(count_ff);
            res_item.last      = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

endmodule

@@ dv/deque_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the double-ended queue with value removal: it follows the
// request and result channels, keeps its own copy of the queue and compares.
// Depends on dwvr_pkg for the request codes, status codes and result layout.
module deque_result_checker
   import dwvr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          results_owed
);

   localparam int SLOTS = 32;

   // Shadow of the queue: ring of words, position of the front entry, fill.
   logic signed [WORD_W-1:0] ring [SLOTS];
   logic [4:0]               front_pos;
   logic [OCC_W-1:0]         held;
   result_type               owed_results [$];

   task automatic queue_result(input logic [31:0] w, input logic has,
                               input status_type st, input logic is_last);
      result_type r;
      r.word      = w;
      r.has_word  = has;
      r.status    = st;
      r.occupancy = held;
      r.last      = is_last;
      owed_results.push_back(r);
   endtask

   // Applies one request to the shadow queue and queues the results it owes.
   task automatic apply_request(input op_type op, input logic [31:0] opnd);
      status_type       st;
      logic [4:0]       pos;
      logic [4:0]       dst;
      logic [OCC_W-1:0] kept;
      int unsigned      n;
      int unsigned      first;
      st = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held == SLOTS) begin
               st = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               front_pos = front_pos - 5'd1;
               ring[front_pos] = opnd;
               held = held + 1'b1;
            end else begin
               pos = front_pos + held[4:0];
               ring[pos] = opnd;
               held = held + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (held == 0) begin
               st = ST_EMPTY;
            end else begin
               if (op == OP_POP_FRONT) front_pos = front_pos + 5'd1;
               held = held - 1'b1;
            end
         end
         OP_REMOVE: begin
            if (held == 0) begin
               st = ST_EMPTY;
            end else begin
               // Survivors slide toward the front, keeping their order.
               kept = '0;
               for (int rd = 0; rd < held; rd++) begin
                  pos = front_pos + 5'(rd);
                  if (ring[pos] != opnd) begin
                     dst = front_pos + kept[4:0];
                     ring[dst] = ring[pos];
                     kept = kept + 1'b1;
                  end
               end
               held = kept;
            end
         end
         OP_CLEAR: begin
            front_pos = '0;
            held = '0;
         end
         default: begin
            // Emits: a negative count means none, and the count is cut to the fill.
            n = opnd[31] ? 0 : opnd;
            if (n > held) n = held;
            if (n != 0) begin
               first = (op == OP_EMIT_FIRST) ? 0 : held - n;
               for (int i = 0; i < n; i++) begin
                  pos = front_pos + 5'(first + i);
                  queue_result(ring[pos], 1'b1, ST_OK, i == n - 1);
               end
               return;
            end
         end
      endcase
      queue_result('0, 1'b0, st, 1'b1);
   endtask

   task automatic check_result();
      result_type want;
      if (owed_results.size() == 0) begin
         $error("result with nothing owed: tdata %h tuser %h tlast %b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         mismatch_count++;
         return;
      end
      want = owed_results.pop_front();
      if (rsp_tdata[31:0] !== want.word) begin
         $error("word: expected %0d, got %0d", want.word, $signed(rsp_tdata[31:0]));
         mismatch_count++;
      end
      if (rsp_tuser[0] !== want.has_word) begin
         $error("has_word: expected %0d, got %0d", want.has_word, rsp_tuser[0]);
         mismatch_count++;
      end
      if (rsp_tuser[2:1] !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:1]);
         mismatch_count++;
      end
      if (rsp_tdata[37:32] !== want.occupancy) begin
         $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_tdata[37:32]);
         mismatch_count++;
      end
      if (rsp_tlast !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, rsp_tlast);
         mismatch_count++;
      end
   endtask

   // A request taken at an edge is applied before a result taken at the same
   // edge is checked; the new results queue behind any still owed.
   always @(posedge clock) begin
      if (reset) begin
         front_pos = '0;
         held = '0;
         owed_results.delete();
      end else begin
         if (req_tvalid && req_tready) apply_request(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      results_owed = owed_results.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the testbench for the double-ended queue with value removal: clock,
// reset, request stimulus, result back-pressure and the verdict.
// Depends on dwvr_pkg, the block deque_with_value_removal and deque_result_checker.
module testbench;
   import dwvr_pkg::*;

   // Kinds of random runs; all but the mixed one lean toward one request sort
   // so the queue regularly fills, drains to empty and sees matching removes.
   typedef enum {RUN_FILL, RUN_DRAIN, RUN_SEARCH, RUN_MIXED} run_kind_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] operand
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] word, [37:32] occupancy, [39:38] zero
   logic [2:0]  rsp_tuser;        // [0] has_word, [2:1] status
   logic        rsp_tlast;

   int mismatch_count;
   int results_owed;

   // Percent of cycles in which the sender holds back a request and the
   // receiver refuses a result; changed between the random phases.
   int req_idle_pct = 33;
   int rsp_idle_pct = 45;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   deque_with_value_removal dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   deque_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // Receiver back-pressure, a fresh coin toss every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Hands one request to the block. Called at a rising edge; returns at the
   // edge that takes the request. Every input and every output of the block
   // changes only just after a rising edge, so ready as seen at the falling
   // edge is what the next rising edge sees.
   task automatic send_request(input op_type op, input logic [31:0] opnd);
      bit taken;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= opnd;
      taken = 1'b0;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Words for pushes and removes: a small pool so removes find matches,
   // the extremes of the signed range, minus one and zero, and fully random words.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 5));
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0000_0000;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Emit counts: mostly small, some around the depth, and some fully random
   // words, which are negative half the time and otherwise far too large.
   function automatic logic [31:0] pick_count();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'($urandom_range(28, 40));
         default: return 32'($urandom_range(0, 8));
      endcase
   endfunction

   function automatic op_type choose_op(input run_kind_type kind);
      int     roll;
      op_type op;
      roll = $urandom_range(0, 99);
      case (kind)
         RUN_FILL: if (roll < 85) return roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
         RUN_DRAIN: if (roll < 70) return roll[0] ? OP_POP_FRONT : OP_POP_BACK;
         RUN_SEARCH: begin
            if (roll < 35) return roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
            if (roll < 65) return OP_REMOVE;
            if (roll < 90) return roll[0] ? OP_EMIT_FIRST : OP_EMIT_LAST;
         end
         default: ;
      endcase
      // Anything at all, but a clear is kept rare so the queue can grow.
      op = op_type'($urandom_range(0, 7));
      if (op == OP_CLEAR && $urandom_range(0, 2) != 0) op = OP_PUSH_BACK;
      return op;
   endfunction

   // Random runs until count requests have gone in; the last run is cut
   // short. Fill runs are longer than the queue is deep and mostly pushes,
   // so the queue tends to fill up and see pushes past full.
   task automatic random_phase(input int count);
      int           sent;
      int           run_len;
      run_kind_type kind;
      op_type       op;
      logic [31:0]  opnd;
      sent = 0;
      while (sent < count) begin
         kind = run_kind_type'($urandom_range(0, 3));
         run_len = (kind == RUN_FILL) ? $urandom_range(36, 56) : $urandom_range(8, 30);
         if (run_len > count - sent) run_len = count - sent;
         repeat (run_len) begin
            op = choose_op(kind);
            if (op == OP_EMIT_FIRST || op == OP_EMIT_LAST)
               opnd = pick_count();
            else if (kind == RUN_SEARCH && $urandom_range(0, 3) != 0)
               opnd = 32'($urandom_range(0, 5));
            else
               opnd = pick_word();
            send_request(op, opnd);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the empty queue: both pops, a remove, and emits
      // that deliver nothing (a plain count and a negative one).
      send_request(OP_POP_FRONT, 32'h0000_0000);
      send_request(OP_POP_BACK, 32'hffff_ffff);
      send_request(OP_REMOVE, 32'h0000_0000);
      send_request(OP_EMIT_FIRST, 32'd5);
      send_request(OP_EMIT_LAST, 32'hffff_ffff);
      // Fill from both ends with the extreme words, the largest word twice.
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      send_request(OP_PUSH_BACK, 32'h7fff_ffff);
      send_request(OP_PUSH_FRONT, 32'hffff_ffff);
      send_request(OP_PUSH_BACK, 32'h0000_0000);
      send_request(OP_PUSH_BACK, 32'h7fff_ffff);
      // An emit with the largest count is cut to the occupancy.
      send_request(OP_EMIT_FIRST, 32'h7fff_ffff);
      // Remove with two matches, then one with no match at all.
      send_request(OP_REMOVE, 32'h7fff_ffff);
      send_request(OP_REMOVE, 32'h1234_5678);
      send_request(OP_EMIT_LAST, 32'd2);
      // A negative count on a non-empty queue emits nothing, as does zero.
      send_request(OP_EMIT_FIRST, 32'h8000_0000);
      send_request(OP_EMIT_LAST, 32'd0);
      send_request(OP_POP_FRONT, 32'h5a5a_5a5a);
      send_request(OP_POP_BACK, 32'ha5a5_a5a5);
      send_request(OP_EMIT_FIRST, 32'd1);
      send_request(OP_CLEAR, 32'hffff_ffff);
      send_request(OP_EMIT_LAST, 32'd3);
      // A remove that empties the queue still reports success.
      send_request(OP_PUSH_BACK, 32'h5555_5555);
      send_request(OP_REMOVE, 32'h5555_5555);

      // Random part in three phases of back-pressure: sender idles less than
      // receiver, then the other way round, then both run flat out.
      random_phase(150);
      req_idle_pct = 45;
      rsp_idle_pct = 33;
      random_phase(150);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase(150);
      req_tvalid <= 1'b0;

      // Drain every owed result, then linger long enough for a full-depth
      // remove or emit to show any stray result.
      do @(negedge clock); while (results_owed != 0);
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Watchdog: ends the run as failed if it has not finished by then.
   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
